// ===== hdl/bpa_pkg.sv =====
// Shared constants, codes and controller/datapath types for the bitmap page allocator.
package bpa_pkg;

  localparam int MAX_PAGES  = 4096;
  localparam int PAGE_BYTES = 4096;
  localparam int ADDR_W     = 24;
  localparam int OP_W       = 2;
  localparam int CNT_W      = 13;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int WORD_BITS  = 64;
  localparam int WB_LOG     = $clog2(WORD_BITS);
  localparam int MAP_WORDS  = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW    = $clog2(MAP_WORDS);

  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_RESERVE = 2'd2,
    OP_INIT    = 2'd3
  } op_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic rd_page;
    logic upd;
    logic init;
    logic rerr;
    logic emit;
  } bpa_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            range_bad;
    logic            found;
    logic            fail;
    logic            out_free;
  } bpa_stat_t;

endpackage

// ===== hdl/bpa_if.sv =====
// Channel interfaces: configuration write, request and response.
interface bpa_cfg_if import bpa_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bpa_req_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] phys_addr;
  modport source (output valid, output op, output phys_addr, input ready);
  modport sink (input valid, input op, input phys_addr, output ready);
endinterface

interface bpa_rsp_if import bpa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] page_addr;
  logic              ok;
  logic [CNT_W-1:0]  used_count;
  logic              range_error;
  modport source (output valid, output page_addr, output ok, output used_count,
                  output range_error, input ready);
  modport sink (input valid, input page_addr, input ok, input used_count,
                input range_error, output ready);
endinterface

// ===== hdl/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bpa_ctrl.sv =====
// Controller state machine: sequences capture, scan, update and result transfer.
module bpa_ctrl import bpa_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  bpa_stat_t stat,
  output bpa_cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_SCAN = 5'b00100,
    S_UPD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        case (stat.op)
          OP_ALLOC: begin
            state_next = S_SCAN;
          end
          OP_INIT: begin
            cmd.init   = 1'b1;
            state_next = S_DONE;
          end
          default: begin
            if (stat.range_bad) begin
              cmd.rerr   = 1'b1;
              state_next = S_DONE;
            end else begin
              cmd.rd_page = 1'b1;
              state_next  = S_UPD;
            end
          end
        endcase
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.found || stat.fail) begin
          state_next = S_DONE;
        end
      end
      S_UPD: begin
        cmd.upd    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        cmd.emit = stat.out_free;
        if (stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_accept_to_decode: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> (state == S_DEC))
    else $error("accepted request did not move to decode");

endmodule

// ===== hdl/bpa_dp.sv =====
// Datapath: page bitmap RAM, row valid bits, used counter, scan logic and result register.
module bpa_dp import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  bpa_cmd_t          cmd,
  output bpa_stat_t         stat,
  input  logic              cfg_valid,
  input  logic [CNT_W-1:0]  cfg_data,
  input  logic [OP_W-1:0]   req_op,
  input  logic [ADDR_W-1:0] req_phys_addr,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output logic [ADDR_W-1:0] rsp_page_addr,
  output logic              rsp_ok,
  output logic [CNT_W-1:0]  rsp_used_count,
  output logic              rsp_range_error
);

  logic [CNT_W-1:0]     managed;
  logic [CNT_W-1:0]     used_total;
  logic [MAP_WORDS-1:0] row_valid;
  logic [OP_W-1:0]      op_q;
  logic [PAGE_W-1:0]    page_q;
  logic [WORD_AW:0]     issue_ptr;
  logic                 chk_vld;
  logic [WORD_AW-1:0]   data_row;

  logic [ADDR_W-1:0] pend_addr;
  logic              pend_ok;
  logic              pend_rerr;

  logic [CNT_W-1:0]     n_eff;
  logic [CNT_W-1:0]     n_round;
  logic [WORD_AW:0]     nwords;
  logic [CNT_W-1:0]     rem;
  logic                 issue;
  logic                 re;
  logic [WORD_AW-1:0]   raddr;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] avail;
  logic [WORD_BITS-1:0] free_vec;
  logic [WORD_BITS-1:0] low;
  logic [WB_LOG-1:0]    bit_idx;
  logic                 found_now;
  logic                 fail_now;
  logic                 upd_bit;
  logic [WORD_BITS-1:0] upd_mask;
  logic                 upd_change;
  logic                 we;
  logic [WORD_BITS-1:0] wdata;
  logic                 cnt_dn;
  logic [CNT_W-1:0]     used_inc;
  logic [CNT_W-1:0]     used_dec;

  assign n_eff   = (managed > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : managed;
  assign n_round = n_eff + CNT_W'(WORD_BITS - 1);
  assign nwords  = n_round[WORD_AW+WB_LOG:WB_LOG];

  assign issue = cmd.scan && (issue_ptr < nwords);
  assign re    = issue || cmd.rd_page;
  assign raddr = cmd.scan ? issue_ptr[WORD_AW-1:0] : page_q[PAGE_W-1:WB_LOG];

  bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(MAP_WORDS)) u_map (
    .clk   (clk),
    .we    (we),
    .waddr (data_row),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // A row not written since reset or init reads as all pages used.
  assign word = row_valid[data_row] ? rdata : '1;
  assign rem  = n_eff - (CNT_W'(data_row) << WB_LOG);

  always_comb begin
    for (int b = 0; b < WORD_BITS; b++) begin
      avail[b] = CNT_W'(b) < rem;
    end
  end

  assign free_vec = ~word & avail;
  assign low      = free_vec & (~free_vec + WORD_BITS'(1));

  always_comb begin
    bit_idx = '0;
    for (int k = 0; k < WB_LOG; k++) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (((b >> k) & 1) == 1) begin
          bit_idx[k] = bit_idx[k] | low[b];
        end
      end
    end
  end

  assign found_now = cmd.scan && stat.found;
  assign fail_now  = cmd.scan && stat.fail;

  assign upd_bit    = word[page_q[WB_LOG-1:0]];
  assign upd_mask   = WORD_BITS'(1) << page_q[WB_LOG-1:0];
  assign upd_change = (op_q == OP_FREE) ? upd_bit : !upd_bit;

  always_comb begin
    we    = 1'b0;
    wdata = word | low;
    if (found_now) begin
      we = 1'b1;
    end else if (cmd.upd && upd_change) begin
      we    = 1'b1;
      wdata = (op_q == OP_FREE) ? (word & ~upd_mask) : (word | upd_mask);
    end
  end

  assign cnt_dn   = cmd.upd && (op_q == OP_FREE);
  assign used_inc = (used_total == COUNT_MAX) ? used_total : used_total + CNT_W'(1);
  assign used_dec = (used_total == '0) ? used_total : used_total - CNT_W'(1);

  always_comb begin
    stat           = '0;
    stat.op        = op_q;
    stat.range_bad = CNT_W'(page_q) >= n_eff;
    stat.found     = chk_vld && (|free_vec);
    stat.fail      = !chk_vld && (issue_ptr >= nwords);
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      managed    <= CNT_W'(MAX_PAGES);
      used_total <= CNT_W'(MAX_PAGES);
      row_valid  <= '0;
      issue_ptr  <= '0;
      chk_vld    <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        managed <= cfg_data;
      end
      chk_vld <= issue;
      if (cmd.capture) begin
        issue_ptr <= '0;
      end else if (issue) begin
        issue_ptr <= issue_ptr + (WORD_AW+1)'(1);
      end
      if (cmd.init) begin
        row_valid  <= '0;
        used_total <= n_eff;
      end else if (we) begin
        row_valid[data_row] <= 1'b1;
        used_total          <= cnt_dn ? used_dec : used_inc;
      end
      if (cmd.emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= req_op;
      page_q <= req_phys_addr[PAGE_SHIFT +: PAGE_W];
    end
    if (re) begin
      data_row <= raddr;
    end
    if (found_now) begin
      pend_addr <= ADDR_W'({data_row, bit_idx}) << PAGE_SHIFT;
      pend_ok   <= 1'b1;
      pend_rerr <= 1'b0;
    end else if (fail_now) begin
      pend_addr <= '0;
      pend_ok   <= 1'b0;
      pend_rerr <= 1'b0;
    end else if (cmd.upd) begin
      pend_addr <= ADDR_W'(page_q) << PAGE_SHIFT;
      pend_ok   <= upd_change;
      pend_rerr <= 1'b0;
    end else if (cmd.rerr) begin
      pend_addr <= '0;
      pend_ok   <= 1'b0;
      pend_rerr <= 1'b1;
    end else if (cmd.init) begin
      pend_addr <= '0;
      pend_ok   <= 1'b1;
      pend_rerr <= 1'b0;
    end
    if (cmd.emit) begin
      rsp_page_addr   <= pend_addr;
      rsp_ok          <= pend_ok;
      rsp_used_count  <= used_total;
      rsp_range_error <= pend_rerr;
    end
  end

  a_scan_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(found_now && fail_now))
    else $error("scan reported both a free page and a failure");

  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    found_now |-> (CNT_W'({data_row, bit_idx}) < n_eff))
    else $error("allocated page lies beyond the managed count");

  a_init_count: assert property (@(posedge clk) disable iff (rst)
    cmd.init |=> (used_total == $past(n_eff)))
    else $error("init did not load the used count");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> rsp_valid)
    else $error("result register not loaded after emit");

endmodule

// ===== hdl/bitmap_page_allocator.sv =====
// Top level of the bitmap page allocator: controller, datapath and channel wiring.
//
//   Channel  Dir  Payload                                   Transfer
//   cfg      in   data (managed_pages, 13b)                 valid & ready
//   req      in   op (2b), phys_addr (24b)                  valid & ready
//   rsp      out  page_addr, ok, used_count, range_error    valid & ready
//
// Alloc runs decode, a scan of the 64-page bitmap words up to the one with the
// free page, and done; the next word read overlaps the check of the last. A
// failing scan reads every bitmap word of the managed pages. Free and reserve
// run decode, update and done; init and out-of-range items decode and done. One
// item is in flight at a time; a new request is taken while the previous result
// waits in the output register. Reset is synchronous and needs no clearing pass:
// per-word valid bits make untouched words read as all used. cfg is always ready.
module bitmap_page_allocator import bpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  bpa_cfg_if.sink   cfg,
  bpa_req_if.sink   req,
  bpa_rsp_if.source rsp
);

  bpa_cmd_t  cmd;
  bpa_stat_t stat;

  assign cfg.ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  bpa_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_valid       (cfg.valid),
    .cfg_data        (cfg.data),
    .req_op          (req.op),
    .req_phys_addr   (req.phys_addr),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_page_addr   (rsp.page_addr),
    .rsp_ok          (rsp.ok),
    .rsp_used_count  (rsp.used_count),
    .rsp_range_error (rsp.range_error)
  );

endmodule
